// File: hw/rtl/pipt_pkg.sv
// Package for the point-in-polygon crossing test.
// Holds the fixed constants and the flag struct shared by the front, queue and back.
// No dependencies.
package pipt_pkg;

	// A polygon needs this many vertices before it can enclose the point.
	localparam int unsigned MIN_VERTICES = 3;
	localparam int unsigned TALLY_W      = 2;

	// Decoupling queue between front and back.
	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// Per-request control bits that travel with the edge operands.
	typedef struct packed {
		logic first;      // vertex opened a polygon, parity restarts
		logic close;      // polygon closes, a result is produced
		logic enough;     // polygon has at least MIN_VERTICES vertices
		logic last_tile;  // result closes the tile
	} pipt_flags_t;

endpackage

// File: hw/rtl/pipt_front.sv
// Front part of the point-in-polygon test: vertex bookkeeping and edge operand setup.
// Depends on pipt_pkg.
module pipt_front #(
	parameter int COORD_BITS = 24
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            accept,
	input  logic signed [COORD_BITS-1:0]    vertex_x,
	input  logic signed [COORD_BITS-1:0]    vertex_y,
	input  logic signed [COORD_BITS-1:0]    point_x,
	input  logic signed [COORD_BITS-1:0]    point_y,
	input  logic                            first_of_polygon,
	input  logic                            last_of_polygon,
	input  logic                            last_of_tile,
	output logic [2*(4*(COORD_BITS+1)+2)-1:0] edge_data,
	output pipt_pkg::pipt_flags_t           flags
);

	localparam int DW     = COORD_BITS + 1;
	localparam int EDGE_W = 4 * DW + 2;

	logic signed [COORD_BITS-1:0]           first_vx_q, first_vy_q, prev_vx_q, prev_vy_q;
	logic [pipt_pkg::TALLY_W-1:0]           tally_q, tally_new;
	logic signed [COORD_BITS-1:0]           first_x, first_y;
	logic [EDGE_W-1:0]                      mid_ops, cls_ops, mid_edge, cls_edge;
	logic                                   close;

	// Operands of one edge test: the straddle gate, the sign of the edge's y span
	// and the four differences whose products are compared in the back part.
	function automatic logic [EDGE_W-1:0] edge_ops(
		input logic signed [COORD_BITS-1:0] ax,
		input logic signed [COORD_BITS-1:0] ay,
		input logic signed [COORD_BITS-1:0] bx,
		input logic signed [COORD_BITS-1:0] by,
		input logic signed [COORD_BITS-1:0] px,
		input logic signed [COORD_BITS-1:0] py
	);
		logic signed [DW-1:0] dxpa, dyba, dxba, dypa;
		logic                 gate, dpos;
		gate = (ay > py) != (by > py);
		dpos = by > ay;
		dxpa = DW'(px) - DW'(ax);
		dyba = DW'(by) - DW'(ay);
		dxba = DW'(bx) - DW'(ax);
		dypa = DW'(py) - DW'(ay);
		return {gate, dpos, dxpa, dyba, dxba, dypa};
	endfunction

	assign close   = last_of_polygon | last_of_tile;
	assign first_x = first_of_polygon ? vertex_x : first_vx_q;
	assign first_y = first_of_polygon ? vertex_y : first_vy_q;

	always_comb begin
		mid_ops = edge_ops(vertex_x, vertex_y, prev_vx_q, prev_vy_q, point_x, point_y);
		cls_ops = edge_ops(first_x, first_y, vertex_x, vertex_y, point_x, point_y);
		mid_edge = mid_ops;
		cls_edge = cls_ops;
		// An opening vertex has no incoming edge; only a closing vertex tests the closing edge.
		mid_edge[EDGE_W-1] = mid_ops[EDGE_W-1] & ~first_of_polygon;
		cls_edge[EDGE_W-1] = cls_ops[EDGE_W-1] & close;
	end

	always_comb begin
		if (first_of_polygon) begin
			tally_new = pipt_pkg::TALLY_W'(1);
		end else if (tally_q == pipt_pkg::TALLY_W'(3)) begin
			tally_new = tally_q;
		end else begin
			tally_new = tally_q + pipt_pkg::TALLY_W'(1);
		end
	end

	assign edge_data       = {cls_edge, mid_edge};
	assign flags.first     = first_of_polygon;
	assign flags.close     = close;
	assign flags.enough    = tally_new >= pipt_pkg::TALLY_W'(pipt_pkg::MIN_VERTICES);
	assign flags.last_tile = last_of_tile;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_vx_q <= '0;
			first_vy_q <= '0;
			prev_vx_q  <= '0;
			prev_vy_q  <= '0;
			tally_q    <= '0;
		end else if (accept) begin
			prev_vx_q <= vertex_x;
			prev_vy_q <= vertex_y;
			if (first_of_polygon) begin
				first_vx_q <= vertex_x;
				first_vy_q <= vertex_y;
			end
			tally_q <= close ? '0 : tally_new;
		end
	end

endmodule

// File: hw/rtl/pipt_queue.sv
// Short first-in first-out queue between the front and back parts.
// Depends on pipt_pkg.
module pipt_queue #(
	parameter int DATA_W = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  logic [DATA_W-1:0]     push_data,
	input  pipt_pkg::pipt_flags_t push_flags,
	output logic                  full,
	output logic                  head_valid,
	input  logic                  head_stall,
	output logic [DATA_W-1:0]     head_data,
	output pipt_pkg::pipt_flags_t head_flags
);

	logic [DATA_W-1:0]                data_q  [pipt_pkg::QUEUE_DEPTH];
	pipt_pkg::pipt_flags_t            flags_q [pipt_pkg::QUEUE_DEPTH];
	logic [pipt_pkg::QPTR_W-1:0]      wr_ptr_q, rd_ptr_q;
	logic [pipt_pkg::QCNT_W-1:0]      count_q;
	logic                             pop;

	function automatic logic [pipt_pkg::QPTR_W-1:0] next_ptr(
		input logic [pipt_pkg::QPTR_W-1:0] ptr
	);
		return (ptr == pipt_pkg::QPTR_W'(pipt_pkg::QUEUE_DEPTH - 1)) ?
			'0 : ptr + pipt_pkg::QPTR_W'(1);
	endfunction

	assign full       = count_q == pipt_pkg::QCNT_W'(pipt_pkg::QUEUE_DEPTH);
	assign head_valid = count_q != '0;
	assign pop        = head_valid & ~head_stall;
	assign head_data  = data_q[rd_ptr_q];
	assign head_flags = flags_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			data_q[wr_ptr_q]  <= push_data;
			flags_q[wr_ptr_q] <= push_flags;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + pipt_pkg::QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - pipt_pkg::QCNT_W'(1);
			end
		end
	end

endmodule

// File: hw/rtl/pipt_back.sv
// Back part of the point-in-polygon test: cross products, compares, parity and results.
// Depends on pipt_pkg.
module pipt_back #(
	parameter int COORD_BITS = 24
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              head_valid,
	output logic                              head_stall,
	input  logic [2*(4*(COORD_BITS+1)+2)-1:0] head_data,
	input  pipt_pkg::pipt_flags_t             head_flags,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic                              polygon_inside,
	output logic                              tile_inside,
	output logic                              tile_done
);

	localparam int DW     = COORD_BITS + 1;
	localparam int PW     = 2 * DW;
	localparam int EDGE_W = 4 * DW + 2;

	logic                  en;
	logic [EDGE_W-1:0]     mid_edge, cls_edge;
	logic signed [PW-1:0]  l_mid, r_mid, l_cls, r_cls;
	logic signed [PW-1:0]  l_mid_s2, r_mid_s2, l_cls_s2, r_cls_s2;
	logic                  gate_mid_s2, dpos_mid_s2, gate_cls_s2, dpos_cls_s2;
	pipt_pkg::pipt_flags_t flags_s2;
	logic                  valid_s2;
	logic                  parity_q, tile_q;
	logic                  c_mid, c_cls, p_mid, p_all, poly_in, tany;
	logic                  out_valid_q, polygon_inside_q, tile_inside_q, tile_done_q;

	// The whole back part holds while a finished result waits unclaimed.
	assign en         = ~(out_valid_q & out_stall);
	assign head_stall = ~en;

	assign mid_edge = head_data[EDGE_W-1:0];
	assign cls_edge = head_data[2*EDGE_W-1:EDGE_W];

	always_comb begin
		l_mid = $signed(mid_edge[4*DW-1:3*DW]) * $signed(mid_edge[3*DW-1:2*DW]);
		r_mid = $signed(mid_edge[2*DW-1:DW])   * $signed(mid_edge[DW-1:0]);
		l_cls = $signed(cls_edge[4*DW-1:3*DW]) * $signed(cls_edge[3*DW-1:2*DW]);
		r_cls = $signed(cls_edge[2*DW-1:DW])   * $signed(cls_edge[DW-1:0]);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			l_mid_s2    <= l_mid;
			r_mid_s2    <= r_mid;
			l_cls_s2    <= l_cls;
			r_cls_s2    <= r_cls;
			gate_mid_s2 <= mid_edge[EDGE_W-1];
			dpos_mid_s2 <= mid_edge[EDGE_W-2];
			gate_cls_s2 <= cls_edge[EDGE_W-1];
			dpos_cls_s2 <= cls_edge[EDGE_W-2];
			flags_s2    <= head_flags;
		end
	end

	// The compare direction flips with the sign of the edge's y span, which
	// replaces the division in the intersection formula.
	always_comb begin
		c_mid   = gate_mid_s2 & (dpos_mid_s2 ? (l_mid_s2 < r_mid_s2) : (r_mid_s2 < l_mid_s2));
		c_cls   = gate_cls_s2 & (dpos_cls_s2 ? (l_cls_s2 < r_cls_s2) : (r_cls_s2 < l_cls_s2));
		p_mid   = (flags_s2.first ? 1'b0 : parity_q) ^ c_mid;
		p_all   = p_mid ^ c_cls;
		poly_in = flags_s2.enough & p_all;
		tany    = tile_q | poly_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2    <= 1'b0;
			parity_q    <= 1'b0;
			tile_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			valid_s2    <= head_valid;
			out_valid_q <= valid_s2 & flags_s2.close;
			if (valid_s2) begin
				if (flags_s2.close) begin
					parity_q <= 1'b0;
					tile_q   <= flags_s2.last_tile ? 1'b0 : tany;
				end else begin
					parity_q <= p_mid;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en && valid_s2 && flags_s2.close) begin
			polygon_inside_q <= poly_in;
			tile_inside_q    <= tany;
			tile_done_q      <= flags_s2.last_tile;
		end
	end

	assign out_valid      = out_valid_q;
	assign polygon_inside = polygon_inside_q;
	assign tile_inside    = tile_inside_q;
	assign tile_done      = tile_done_q;

endmodule

// File: hw/rtl/point_in_polygon_test.sv
// Top level of the even-odd point-in-polygon test.
// Depends on pipt_pkg, pipt_front, pipt_queue and pipt_back.
//
// Usage: one vertex request per cycle enters on the in channel (in_valid, in_stall)
// with the query point and the polygon and tile marks. A request is taken at a rising
// edge where in_valid is high and in_stall is low. Every vertex that closes a polygon
// (last_of_polygon or last_of_tile set) yields exactly one result request on the out
// channel (out_valid, out_stall); other vertices yield none.
// A closing vertex passes the queue, the multiply registers and the output register
// before its result shows. Throughput: one vertex per cycle sustained while in_stall is
// low, closing vertices too: the incoming and the closing edge run in parallel multiplier lanes.
// The front part keeps the first and previous vertex and a saturating vertex tally and
// forms the edge differences; a four-entry queue then feeds the back part, which has
// one multiply stage and one compare, parity and result stage.
// When the receiver stalls, the result stays in the output register and the back part
// holds; the front keeps taking vertices until the queue fills and in_stall rises.
// Reset clears the vertex state, the parity, the tile flag and all valid bits; the
// block is ready as soon as reset is released.
module point_in_polygon_test #(
	parameter int COORD_BITS = 24
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic signed [COORD_BITS-1:0] vertex_x,
	input  logic signed [COORD_BITS-1:0] vertex_y,
	input  logic signed [COORD_BITS-1:0] point_x,
	input  logic signed [COORD_BITS-1:0] point_y,
	input  logic                         first_of_polygon,
	input  logic                         last_of_polygon,
	input  logic                         last_of_tile,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic                         polygon_inside,
	output logic                         tile_inside,
	output logic                         tile_done
);

	// One edge carries a gate bit, a sign bit and four differences one bit wider
	// than a coordinate; a request carries the incoming and the closing edge.
	localparam int DATA_W = 2 * (4 * (COORD_BITS + 1) + 2);

	logic                  accept;
	logic                  q_full;
	logic [DATA_W-1:0]     front_data, head_data;
	pipt_pkg::pipt_flags_t front_flags, head_flags;
	logic                  head_valid, head_stall;

	assign in_stall = q_full;
	assign accept   = in_valid & ~q_full;

	pipt_front #(
		.COORD_BITS(COORD_BITS)
	) u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.accept           (accept),
		.vertex_x         (vertex_x),
		.vertex_y         (vertex_y),
		.point_x          (point_x),
		.point_y          (point_y),
		.first_of_polygon (first_of_polygon),
		.last_of_polygon  (last_of_polygon),
		.last_of_tile     (last_of_tile),
		.edge_data        (front_data),
		.flags            (front_flags)
	);

	pipt_queue #(
		.DATA_W(DATA_W)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (accept),
		.push_data  (front_data),
		.push_flags (front_flags),
		.full       (q_full),
		.head_valid (head_valid),
		.head_stall (head_stall),
		.head_data  (head_data),
		.head_flags (head_flags)
	);

	pipt_back #(
		.COORD_BITS(COORD_BITS)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.head_valid     (head_valid),
		.head_stall     (head_stall),
		.head_data      (head_data),
		.head_flags     (head_flags),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.polygon_inside (polygon_inside),
		.tile_inside    (tile_inside),
		.tile_done      (tile_done)
	);

endmodule
